// File: src/gda_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gda_pkg
// Shared types, constants and calendar helpers for the Gregorian date
// add/subtract block.
// ---------------------------------------------------------------------------
package gda_pkg;

    // field widths
    localparam int MODE_W  = 3;
    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int ERR_W   = 2;
    // year modulo 400 fits in 9 bits
    localparam int R400_W  = 9;

    // parameter defaults
    localparam int COUNT_WIDTH_DEF = 16;
    localparam int MAX_YEAR_DEF    = 9999;

    // mode codes
    localparam logic [MODE_W-1:0] MODE_LOAD = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ADD  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SUB  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_NEXT = 3'd3;
    localparam logic [MODE_W-1:0] MODE_PREV = 3'd4;

    // error codes
    localparam logic [ERR_W-1:0] ERR_OK       = 2'd0;
    localparam logic [ERR_W-1:0] ERR_BAD_DATE = 2'd1;
    localparam logic [ERR_W-1:0] ERR_RANGE    = 2'd2;

    // calendar constants
    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
    localparam logic [YEAR_W-1:0]  YEAR_400  = 14'd400;
    localparam logic [R400_W-1:0]  R400_LAST = 9'd399;
    localparam logic [R400_W-1:0]  R400_100  = 9'd100;
    localparam logic [R400_W-1:0]  R400_200  = 9'd200;
    localparam logic [R400_W-1:0]  R400_300  = 9'd300;
    localparam logic [DAY_W-1:0]   LEN_31    = 5'd31;
    localparam logic [DAY_W-1:0]   LEN_30    = 5'd30;
    localparam logic [DAY_W-1:0]   LEN_29    = 5'd29;
    localparam logic [DAY_W-1:0]   LEN_28    = 5'd28;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_ADD,
        S_SUB,
        S_OUT
    } state_t;

    // position of the month walk
    typedef struct packed {
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
        logic [R400_W-1:0]  r400;
    } walk_pos_t;

    // result of one month step
    typedef struct packed {
        walk_pos_t pos;
        logic      done;
        logic      bad;
    } step_res_t;

    // leap year from year mod 400
    function automatic logic is_leap(input logic [R400_W-1:0] r);
        is_leap = (r[1:0] == 2'b00) && (r != R400_100) && (r != R400_200)
                  && (r != R400_300);
    endfunction

    // days in a month
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                    input logic lp);
        case (m) inside
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: month_len = LEN_30;
            MONTH_FEB: month_len = lp ? LEN_29 : LEN_28;
            default:   month_len = LEN_31;
        endcase
    endfunction

endpackage

// File: src/gda_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gda_in_if / gda_out_if
// Valid/ready channels carrying date requests and date results.
// ---------------------------------------------------------------------------
interface gda_in_if import gda_pkg::*; #(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) ();
    logic                   valid;
    logic                   ready;
    logic [MODE_W-1:0]      mode;
    logic [DAY_W-1:0]       in_day;
    logic [MONTH_W-1:0]     in_month;
    logic [YEAR_W-1:0]      in_year;
    logic [COUNT_WIDTH-1:0] day_count;

    modport source (output valid, mode, in_day, in_month, in_year, day_count,
                    input ready);
    modport sink   (input valid, mode, in_day, in_month, in_year, day_count,
                    output ready);
endinterface

interface gda_out_if import gda_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [DAY_W-1:0]   res_day;
    logic [MONTH_W-1:0] res_month;
    logic [YEAR_W-1:0]  res_year;
    logic [ERR_W-1:0]   error;

    modport source (output valid, res_day, res_month, res_year, error,
                    input ready);
    modport sink   (input valid, res_day, res_month, res_year, error,
                    output ready);
endinterface

// File: src/gda_step_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gda_step_unit
// One month step of the date walk: forward (drop the current month's length)
// or backward (borrow the previous month's length), with year carry/borrow.
// ---------------------------------------------------------------------------
module gda_step_unit import gda_pkg::*; #(
    parameter int AW       = 18,
    parameter int MAX_YEAR = MAX_YEAR_DEF
) (
    input  logic                 dir_sub,
    input  logic signed [AW-1:0] acc,
    input  walk_pos_t            pos,
    output logic signed [AW-1:0] acc_next,
    output step_res_t            res
);

    localparam logic [YEAR_W-1:0] MAX_Y = YEAR_W'(MAX_YEAR);
    localparam logic [YEAR_W-1:0] MIN_Y = YEAR_W'(1);

    walk_pos_t          fwd;
    walk_pos_t          bwd;
    walk_pos_t          len_pos;
    logic               fwd_bad;
    logic               bwd_bad;
    logic [DAY_W-1:0]   len;
    logic signed [AW-1:0] len_s;

    // neighbor months
    always_comb
    begin
        fwd     = pos;
        bwd     = pos;
        fwd_bad = 1'b0;
        bwd_bad = 1'b0;
        if (pos.month == MONTH_DEC)
        begin
            fwd_bad   = (pos.year == MAX_Y);
            fwd.month = MONTH_JAN;
            fwd.year  = pos.year + YEAR_W'(1);
            fwd.r400  = (pos.r400 == R400_LAST) ? '0 : pos.r400 + R400_W'(1);
        end
        else
        begin
            fwd.month = pos.month + MONTH_W'(1);
        end
        if (pos.month == MONTH_JAN)
        begin
            bwd_bad   = (pos.year == MIN_Y);
            bwd.month = MONTH_DEC;
            bwd.year  = pos.year - YEAR_W'(1);
            bwd.r400  = (pos.r400 == '0) ? R400_LAST : pos.r400 - R400_W'(1);
        end
        else
        begin
            bwd.month = pos.month - MONTH_W'(1);
        end
    end

    // one length lookup, one adder
    assign len_pos = dir_sub ? bwd : pos;
    assign len     = month_len(len_pos.month, is_leap(len_pos.r400));
    assign len_s   = $signed(AW'(len));

    always_comb
    begin
        if (dir_sub)
        begin
            res.done = (acc > $signed(AW'(0)));
            res.bad  = !res.done && bwd_bad;
            res.pos  = bwd;
            acc_next = acc + len_s;
        end
        else
        begin
            res.done = (acc <= len_s);
            res.bad  = !res.done && fwd_bad;
            res.pos  = fwd;
            acc_next = acc - len_s;
        end
    end

endmodule

// File: src/gregorian_date_add_subtract.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gregorian_date_add_subtract
// Stored Gregorian date with load, add/subtract N days and next/previous day.
// ---------------------------------------------------------------------------
//  channel | dir | payload                                       | handshake
//  in_ch   | in  | mode, in_day, in_month, in_year, day_count    | valid/ready
//  out_ch  | out | res_day, res_month, res_year, error           | valid/ready
//
//  One item at a time; ready is high only while idle.
//  Load: year mod 400 by repeated subtraction of 400.
//  Add/subtract: one month walked per cycle (about day_count / 30 months).
//  Next/previous walk a count of one day; unused modes go straight to the
//  result. The month step unit sets the walk rate. The result then waits
//  for out_ch.ready. Reset sets the stored date to 0001-01-01.
// ---------------------------------------------------------------------------
module gregorian_date_add_subtract import gda_pkg::*; #(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
    parameter int MAX_YEAR    = MAX_YEAR_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    gda_in_if.sink     in_ch,
    gda_out_if.source  out_ch
);

    localparam int AW = ((COUNT_WIDTH > DAY_W) ? COUNT_WIDTH : DAY_W) + 2;
    localparam logic [YEAR_W-1:0] MAX_Y = YEAR_W'(MAX_YEAR);

    state_t               state_reg, state_next;
    logic [MODE_W-1:0]    mode_reg, mode_next;
    logic [DAY_W-1:0]     ld_reg, ld_next;
    logic [MONTH_W-1:0]   lm_reg, lm_next;
    logic [YEAR_W-1:0]    ly_reg, ly_next;
    logic [YEAR_W-1:0]    rem_reg, rem_next;
    logic signed [AW-1:0] acc_reg, acc_next;
    walk_pos_t            pos_reg, pos_next;
    logic [DAY_W-1:0]     cur_day_reg, cur_day_next;
    logic [MONTH_W-1:0]   cur_month_reg, cur_month_next;
    logic [YEAR_W-1:0]    cur_year_reg, cur_year_next;
    logic [R400_W-1:0]    cur_r400_reg, cur_r400_next;
    logic [DAY_W-1:0]     res_day_reg, res_day_next;
    logic [MONTH_W-1:0]   res_month_reg, res_month_next;
    logic [YEAR_W-1:0]    res_year_reg, res_year_next;
    logic [ERR_W-1:0]     err_reg, err_next;

    logic [COUNT_WIDTH-1:0] cnt_sel;
    logic                   is_single;
    logic                   load_ok;
    logic signed [AW-1:0]   step_acc;
    step_res_t              step;

    // shared month step unit
    gda_step_unit #(
        .AW       (AW),
        .MAX_YEAR (MAX_YEAR)
    ) u_step (
        .dir_sub  (state_reg == S_SUB),
        .acc      (acc_reg),
        .pos      (pos_reg),
        .acc_next (step_acc),
        .res      (step)
    );

    // next/previous move by one day
    assign is_single = (in_ch.mode == MODE_NEXT) || (in_ch.mode == MODE_PREV);
    assign cnt_sel   = is_single ? COUNT_WIDTH'(1) : in_ch.day_count;

    // load validation, once rem_reg holds year mod 400
    assign load_ok = (lm_reg >= MONTH_JAN) && (lm_reg <= MONTH_DEC)
                     && (ly_reg != '0) && (ly_reg <= MAX_Y)
                     && (ld_reg != '0)
                     && (ld_reg <= month_len(lm_reg, is_leap(rem_reg[R400_W-1:0])));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    case (in_ch.mode) inside
                        MODE_LOAD:            state_next = S_LOAD;
                        MODE_ADD, MODE_NEXT:  state_next = S_ADD;
                        MODE_SUB, MODE_PREV:  state_next = S_SUB;
                        default:              state_next = S_OUT;
                    endcase
                end
            end
            S_LOAD:
            begin
                if (rem_reg < YEAR_400)
                    state_next = S_OUT;
            end
            S_ADD, S_SUB:
            begin
                if (step.done || step.bad)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_ch.ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // handshake and payload outputs
    always_comb
    begin
        in_ch.ready      = (state_reg == S_IDLE);
        out_ch.valid     = (state_reg == S_OUT);
        out_ch.res_day   = res_day_reg;
        out_ch.res_month = res_month_reg;
        out_ch.res_year  = res_year_reg;
        out_ch.error     = err_reg;
    end

    // datapath
    always_comb
    begin
        mode_next      = mode_reg;
        ld_next        = ld_reg;
        lm_next        = lm_reg;
        ly_next        = ly_reg;
        rem_next       = rem_reg;
        acc_next       = acc_reg;
        pos_next       = pos_reg;
        cur_day_next   = cur_day_reg;
        cur_month_next = cur_month_reg;
        cur_year_next  = cur_year_reg;
        cur_r400_next  = cur_r400_reg;
        res_day_next   = res_day_reg;
        res_month_next = res_month_reg;
        res_year_next  = res_year_reg;
        err_next       = err_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    mode_next      = in_ch.mode;
                    ld_next        = in_ch.in_day;
                    lm_next        = in_ch.in_month;
                    ly_next        = in_ch.in_year;
                    rem_next       = in_ch.in_year;
                    pos_next.month = cur_month_reg;
                    pos_next.year  = cur_year_reg;
                    pos_next.r400  = cur_r400_reg;
                    if ((in_ch.mode == MODE_SUB) || (in_ch.mode == MODE_PREV))
                        acc_next = $signed(AW'(cur_day_reg)) - $signed(AW'(cnt_sel));
                    else
                        acc_next = $signed(AW'(cur_day_reg)) + $signed(AW'(cnt_sel));
                    // unused modes report the stored date
                    res_day_next   = cur_day_reg;
                    res_month_next = cur_month_reg;
                    res_year_next  = cur_year_reg;
                    err_next       = ERR_OK;
                end
            end
            S_LOAD:
            begin
                if (rem_reg >= YEAR_400)
                begin
                    rem_next = rem_reg - YEAR_400;
                end
                else if (load_ok)
                begin
                    cur_day_next   = ld_reg;
                    cur_month_next = lm_reg;
                    cur_year_next  = ly_reg;
                    cur_r400_next  = rem_reg[R400_W-1:0];
                    res_day_next   = ld_reg;
                    res_month_next = lm_reg;
                    res_year_next  = ly_reg;
                    err_next       = ERR_OK;
                end
                else
                begin
                    err_next = ERR_BAD_DATE;
                end
            end
            S_ADD, S_SUB:
            begin
                if (step.bad)
                begin
                    err_next = ERR_RANGE;
                end
                else if (step.done)
                begin
                    res_day_next   = acc_reg[DAY_W-1:0];
                    res_month_next = pos_reg.month;
                    res_year_next  = pos_reg.year;
                    err_next       = ERR_OK;
                    // add and subtract keep the new date
                    if ((mode_reg == MODE_ADD) || (mode_reg == MODE_SUB))
                    begin
                        cur_day_next   = acc_reg[DAY_W-1:0];
                        cur_month_next = pos_reg.month;
                        cur_year_next  = pos_reg.year;
                        cur_r400_next  = pos_reg.r400;
                    end
                end
                else
                begin
                    acc_next = step_acc;
                    pos_next = step.pos;
                end
            end
            default:
            begin
            end
        endcase
    end

    // control and stored date
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cur_day_reg   <= DAY_W'(1);
            cur_month_reg <= MONTH_JAN;
            cur_year_reg  <= YEAR_W'(1);
            cur_r400_reg  <= R400_W'(1);
        end
        else
        begin
            state_reg     <= state_next;
            cur_day_reg   <= cur_day_next;
            cur_month_reg <= cur_month_next;
            cur_year_reg  <= cur_year_next;
            cur_r400_reg  <= cur_r400_next;
        end
    end

    // working and result payload
    always_ff @(posedge clk)
    begin
        mode_reg      <= mode_next;
        ld_reg        <= ld_next;
        lm_reg        <= lm_next;
        ly_reg        <= ly_next;
        rem_reg       <= rem_next;
        acc_reg       <= acc_next;
        pos_reg       <= pos_next;
        res_day_reg   <= res_day_next;
        res_month_reg <= res_month_next;
        res_year_reg  <= res_year_next;
        err_reg       <= err_next;
    end

endmodule

// File: test/gregorian_date_add_subtract_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gregorian_date_add_subtract_test
// Self-checking bench for the Gregorian date block. A directed list covers
// invalid loads, leap days, month and year borrow/carry and the year limits.
// A random phase follows: mostly valid loads near calendar boundaries mixed
// with add/subtract/next/previous steps. Both channel sides idle at random,
// and the result side stalls once for a long stretch. A scoreboard class
// tracks its own copy of the stored date, predicts every result and compares
// it field by field in order.
// ---------------------------------------------------------------------------
module gregorian_date_add_subtract_test;
    import gda_pkg::*;

    localparam int COUNT_WIDTH     = COUNT_WIDTH_DEF;
    localparam int MAX_YEAR        = MAX_YEAR_DEF;
    localparam int RANDOM_ITEMS    = 250;
    localparam int STALL_CYCLES    = 300;
    localparam int STALL_AT_RESULT = 80;
    localparam int DRAIN_CYCLES    = 60;
    localparam int PRINT_LIMIT     = 40;
    localparam int MAX_GAP         = 5;

    // codes the block treats as no-ops
    localparam logic [MODE_W-1:0] MODE_SPARE_5 = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_6 = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_7 = 3'd7;

    // years that sit on leap-rule or range boundaries
    localparam int BOUNDARY_YEARS [9] = '{1, 2, 4, 100, 400, 1900, 2000, 9998, 9999};

    typedef struct packed {
        logic [MODE_W-1:0]      mode;
        logic [DAY_W-1:0]       day;
        logic [MONTH_W-1:0]     month;
        logic [YEAR_W-1:0]      year;
        logic [COUNT_WIDTH-1:0] count;
    } date_request_t;

    typedef struct packed {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
        logic [ERR_W-1:0]   error;
    } date_result_t;

    // -----------------------------------------------------------------------
    // Scoreboard: date predictor plus in-order result check
    // -----------------------------------------------------------------------
    class date_scoreboard;
        int           cur_day;
        int           cur_month;
        int           cur_year;
        date_result_t expected_dates[$];
        int           mismatches;
        int           results_checked;
        int           mode_hits[8];

        function new();
            cur_day         = 1;
            cur_month       = 1;
            cur_year        = 1;
            mismatches      = 0;
            results_checked = 0;
            foreach (mode_hits[i]) mode_hits[i] = 0;
        endfunction

        function bit leap_year(int y);
            if (y % 4 != 0) return 1'b0;
            if (y % 100 != 0) return 1'b1;
            return (y % 400) == 0;
        endfunction

        function int days_in_month(int m, int y);
            case (m)
                4, 6, 9, 11: return 30;
                2:           return leap_year(y) ? 29 : 28;
                default:     return 31;
            endcase
        endfunction

        function date_result_t make_result(int d, int m, int y, logic [ERR_W-1:0] e);
            date_result_t res;
            res.day   = DAY_W'(d);
            res.month = MONTH_W'(m);
            res.year  = YEAR_W'(y);
            res.error = e;
            return res;
        endfunction

        // next stored date and reported result for one item
        function date_result_t predict_date(date_request_t r);
            int d;
            int m;
            int y;
            int sd;
            bit bad;
            d   = cur_day;
            m   = cur_month;
            y   = cur_year;
            bad = 1'b0;
            case (r.mode)
                MODE_LOAD: begin
                    if (r.month < MONTH_JAN || r.month > MONTH_DEC || r.year < 1 ||
                        r.year > MAX_YEAR || r.day < 1 ||
                        r.day > days_in_month(r.month, r.year))
                        return make_result(cur_day, cur_month, cur_year, ERR_BAD_DATE);
                    d = r.day;
                    m = r.month;
                    y = r.year;
                end
                MODE_ADD: begin
                    d = d + r.count;
                    while (!bad && d > days_in_month(m, y)) begin
                        d = d - days_in_month(m, y);
                        m++;
                        if (m == 13) begin
                            m = 1;
                            y++;
                            if (y > MAX_YEAR) bad = 1'b1;
                        end
                    end
                end
                MODE_SUB: begin
                    sd = d - int'(r.count);
                    while (!bad && sd < 1) begin
                        if (m == 1) begin
                            m = 12;
                            y--;
                        end
                        else m--;
                        if (y < 1) bad = 1'b1;
                        else sd = sd + days_in_month(m, y);
                    end
                    if (!bad) d = sd;
                end
                MODE_NEXT: begin
                    if (d >= days_in_month(m, y)) begin
                        d = 1;
                        if (m >= 12) begin
                            m = 1;
                            y++;
                            if (y > MAX_YEAR) bad = 1'b1;
                        end
                        else m++;
                    end
                    else d++;
                end
                MODE_PREV: begin
                    // borrow: day becomes the length of the month before
                    if (d <= 1) begin
                        if (m <= 1) begin
                            m = 12;
                            if (y <= 1) bad = 1'b1;
                            else y--;
                        end
                        else m--;
                        d = days_in_month(m, y);
                    end
                    else d--;
                end
                default: ;
            endcase
            if (bad) return make_result(cur_day, cur_month, cur_year, ERR_RANGE);
            if (r.mode <= MODE_SUB) begin
                cur_day   = d;
                cur_month = m;
                cur_year  = y;
            end
            return make_result(d, m, y, ERR_OK);
        endfunction

        function void note_request(date_request_t r);
            mode_hits[r.mode]++;
            expected_dates.push_back(predict_date(r));
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            if (mismatches <= PRINT_LIMIT) $display("[%0t] MISMATCH: %s", $time, msg);
        endtask

        task check_date(date_result_t got);
            date_result_t want;
            if (expected_dates.size() == 0) begin
                report_mismatch($sformatf("unexpected result %0d-%0d-%0d error %0d",
                                          got.year, got.month, got.day, got.error));
                return;
            end
            want = expected_dates.pop_front();
            results_checked++;
            if (got.day !== want.day)
                report_mismatch($sformatf("res_day %0d, want %0d", got.day, want.day));
            if (got.month !== want.month)
                report_mismatch($sformatf("res_month %0d, want %0d", got.month, want.month));
            if (got.year !== want.year)
                report_mismatch($sformatf("res_year %0d, want %0d", got.year, want.year));
            if (got.error !== want.error)
                report_mismatch($sformatf("error %0d, want %0d", got.error, want.error));
        endtask
    endclass

    // -----------------------------------------------------------------------
    // Clock, reset, channels, block
    // -----------------------------------------------------------------------
    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    bit   send_burst = 1'b0;
    bit   sink_burst = 1'b0;
    date_scoreboard sb;

    always #1 clk = ~clk;

    gda_in_if #(.COUNT_WIDTH(COUNT_WIDTH)) in_ch ();
    gda_out_if out_ch ();

    gregorian_date_add_subtract #(
        .COUNT_WIDTH(COUNT_WIDTH),
        .MAX_YEAR   (MAX_YEAR)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_ch),
        .out_ch(out_ch)
    );

    // -----------------------------------------------------------------------
    // Request driver
    // -----------------------------------------------------------------------
    task automatic send_item(input date_request_t r);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.mode      <= r.mode;
        in_ch.in_day    <= r.day;
        in_ch.in_month  <= r.month;
        in_ch.in_year   <= r.year;
        in_ch.day_count <= r.count;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        sb.note_request(r);
        if ($urandom_range(0, 19) == 0) send_burst = !send_burst;
    endtask

    task automatic send_fields(input logic [MODE_W-1:0] mode, input int d, input int m,
                               input int y, input int cnt);
        date_request_t r;
        r.mode  = mode;
        r.day   = DAY_W'(d);
        r.month = MONTH_W'(m);
        r.year  = YEAR_W'(y);
        r.count = COUNT_WIDTH'(cnt);
        send_item(r);
    endtask

    // boundary cases, starting from the reset date 0001-01-01
    task automatic run_directed();
        send_fields(MODE_NEXT, 0, 0, 0, 0);
        send_fields(MODE_PREV, 0, 0, 0, 0);          // below year 1
        send_fields(MODE_SUB, 0, 0, 0, 1);           // below year 1
        send_fields(MODE_ADD, 0, 0, 0, 0);
        send_fields(MODE_SUB, 0, 0, 0, 0);
        send_fields(MODE_LOAD, 0, 1, 1, 0);          // day 0
        send_fields(MODE_LOAD, 1, 0, 2000, 0);       // month 0
        send_fields(MODE_LOAD, 1, 13, 2000, 0);
        send_fields(MODE_LOAD, 31, 15, 16383, 65535); // all fields at max
        send_fields(MODE_LOAD, 1, 1, 0, 0);          // year 0
        send_fields(MODE_LOAD, 1, 1, 10000, 0);
        send_fields(MODE_LOAD, 31, 4, 2023, 0);      // April 31
        send_fields(MODE_LOAD, 29, 2, 1900, 0);      // century, not leap
        send_fields(MODE_LOAD, 29, 2, 2000, 0);      // 400 rule, leap
        send_fields(MODE_NEXT, 0, 0, 0, 0);
        send_fields(MODE_LOAD, 1, 3, 2024, 0);
        send_fields(MODE_PREV, 0, 0, 0, 0);          // back into Feb 29
        send_fields(MODE_LOAD, 1, 1, 2000, 0);
        send_fields(MODE_PREV, 0, 0, 0, 0);          // year borrow
        send_fields(MODE_LOAD, 31, 12, 9999, 0);
        send_fields(MODE_NEXT, 0, 0, 0, 0);          // past last year
        send_fields(MODE_ADD, 0, 0, 0, 1);           // past last year
        send_fields(MODE_SUB, 0, 0, 0, 65535);
        send_fields(MODE_SPARE_5, 31, 15, 16383, 65535);
        send_fields(MODE_SPARE_6, 0, 0, 0, 0);
        send_fields(MODE_SPARE_7, 31, 15, 16383, 65535);
        send_fields(MODE_LOAD, 1, 1, 1, 0);
        send_fields(MODE_ADD, 0, 0, 0, 65535);
    endtask

    // mostly short counts, with the full range now and then
    function automatic int count_draw();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60) return $urandom_range(0, 60);
        if (pick < 85) return $urandom_range(0, 1000);
        if (pick < 95) return $urandom_range(0, 65535);
        return ($urandom_range(0, 1) == 1) ? 65535 : 0;
    endfunction

    function automatic date_request_t random_request();
        date_request_t r;
        int pick;
        int y;
        int m;
        int len;
        // unused fields carry random noise
        r.mode  = MODE_LOAD;
        r.day   = DAY_W'($urandom_range(0, 31));
        r.month = MONTH_W'($urandom_range(0, 15));
        r.year  = YEAR_W'($urandom_range(0, 16383));
        r.count = COUNT_WIDTH'($urandom_range(0, 65535));
        y       = ($urandom_range(0, 9) < 3) ? BOUNDARY_YEARS[$urandom_range(0, 8)]
                                              : $urandom_range(1, MAX_YEAR);
        m       = $urandom_range(1, 12);
        len     = sb.days_in_month(m, y);
        pick    = $urandom_range(0, 99);
        if (pick < 18)
        begin
            // valid load, often on a month end
            r.day   = DAY_W'(($urandom_range(0, 9) < 4) ? len : $urandom_range(1, len));
            r.month = MONTH_W'(m);
            r.year  = YEAR_W'(y);
        end
        else if (pick < 20)
        begin
            // day just past the month end
            r.day   = DAY_W'(len + 1);
            r.month = MONTH_W'(m);
            r.year  = YEAR_W'(y);
        end
        else if (pick < 23) ;  // raw random load fields
        else if (pick < 50)
        begin
            r.mode  = MODE_ADD;
            r.count = COUNT_WIDTH'(count_draw());
        end
        else if (pick < 75)
        begin
            r.mode  = MODE_SUB;
            r.count = COUNT_WIDTH'(count_draw());
        end
        else if (pick < 85) r.mode = MODE_NEXT;
        else if (pick < 95) r.mode = MODE_PREV;
        else
        begin
            case ($urandom_range(0, 2))
                0:       r.mode = MODE_SPARE_5;
                1:       r.mode = MODE_SPARE_6;
                default: r.mode = MODE_SPARE_7;
            endcase
        end
        return r;
    endfunction

    // -----------------------------------------------------------------------
    // Stimulus and end of run
    // -----------------------------------------------------------------------
    initial
    begin : stimulus
        date_request_t req;
        sb = new();
        in_ch.valid     <= 1'b0;
        in_ch.mode      <= MODE_LOAD;
        in_ch.in_day    <= '0;
        in_ch.in_month  <= '0;
        in_ch.in_year   <= '0;
        in_ch.day_count <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            req = random_request();
            send_item(req);
        end
        in_ch.valid <= 1'b0;

        while (sb.expected_dates.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        while (sb.expected_dates.size() != 0)
        begin
            sb.report_mismatch("result never arrived");
            void'(sb.expected_dates.pop_front());
        end

        $display("Sent %0d loads, %0d adds, %0d subtracts, %0d next, %0d previous, %0d no-op",
                 sb.mode_hits[MODE_LOAD], sb.mode_hits[MODE_ADD], sb.mode_hits[MODE_SUB],
                 sb.mode_hits[MODE_NEXT], sb.mode_hits[MODE_PREV],
                 sb.mode_hits[MODE_SPARE_5] + sb.mode_hits[MODE_SPARE_6] +
                 sb.mode_hits[MODE_SPARE_7]);
        $display("Checked %0d results, %0d mismatches", sb.results_checked, sb.mismatches);
        if (sb.mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // -----------------------------------------------------------------------
    // Result receiver, with one long hold-off to back up the input side
    // -----------------------------------------------------------------------
    initial
    begin : result_sink
        int gap;
        date_result_t got;
        out_ch.ready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (sb.results_checked == STALL_AT_RESULT)
            begin
                out_ch.ready <= 1'b0;
                repeat (STALL_CYCLES) @(posedge clk);
            end
            gap = sink_burst ? 0 : $urandom_range(0, MAX_GAP);
            if (gap > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
            while (!out_ch.valid) @(posedge clk);
            got.day   = out_ch.res_day;
            got.month = out_ch.res_month;
            got.year  = out_ch.res_year;
            got.error = out_ch.error;
            sb.check_date(got);
            if ($urandom_range(0, 19) == 0) sink_burst = !sink_burst;
        end
    end

    // watchdog
    initial
    begin : run_limit
        #5_000_000;
        $display("Timeout, %0d results still pending", sb.expected_dates.size());
        $display("Verification failed");
        $finish;
    end

endmodule

// File: sim.f
src/gda_pkg.sv
src/gda_if.sv
src/gda_step_unit.sv
src/gregorian_date_add_subtract.sv
test/gregorian_date_add_subtract_test.sv
